FILE: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define SWMF_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("invariant violated");

// Check a consequence in the same cycle as its trigger.
`define SWMF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Check a consequence in the cycle after its trigger.
`define SWMF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

FILE: rtl/core/swmf_pkg.sv
`default_nettype none

package swmf_pkg;

  // Where a cell's entry goes on the next accepted beat.
  typedef struct packed {
    logic dn;  // moves to the neighbor below
    logic up;  // moves to the neighbor above
  } swmf_move_t;

endpackage

`default_nettype wire

FILE: rtl/core/swmf_cell.sv
`default_nettype none

module swmf_cell #(
  parameter int WINDOW      = 64,
  parameter int SAMPLE_BITS = 16,
  parameter int INDEX       = 0,
  localparam int AGE_BITS   = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          adv,
  input  wire logic signed [SAMPLE_BITS-1:0] new_val,
  input  wire logic signed [SAMPLE_BITS-1:0] old_val,
  input  wire logic signed [SAMPLE_BITS-1:0] lo_val,
  input  wire logic        [AGE_BITS-1:0]    lo_age,
  input  wire swmf_pkg::swmf_move_t          lo_move,
  input  wire logic signed [SAMPLE_BITS-1:0] hi_val,
  input  wire logic        [AGE_BITS-1:0]    hi_age,
  input  wire swmf_pkg::swmf_move_t          hi_move,
  output logic signed      [SAMPLE_BITS-1:0] val_o,
  output logic             [AGE_BITS-1:0]    age_o,
  output swmf_pkg::swmf_move_t               move_o,
  output logic                               old_o,
  output logic                               next_old_o
);

  import swmf_pkg::*;

  localparam logic [AGE_BITS-1:0] AGE_OLD = AGE_BITS'(WINDOW - 1);
  localparam logic [AGE_BITS-1:0] AGE_ONE = AGE_BITS'(1);

  logic signed [SAMPLE_BITS-1:0] val_r, val_nxt;
  logic        [AGE_BITS-1:0]    age_r, age_nxt;
  logic is_old, old_below, new_below, stay;

  // Entries are ordered by (value, age); the evicted entry is the oldest,
  // so an equal value never counts as below; the new one is the youngest.
  assign is_old    = (age_r == AGE_OLD);
  assign old_below = (old_val < val_r);
  assign new_below = (new_val <= val_r);
  assign stay      = !is_old && (old_below == new_below);

  assign move_o.dn = !is_old && old_below && !new_below;
  assign move_o.up = !is_old && !old_below && new_below;

  always_comb begin
    if (hi_move.dn) begin
      val_nxt = hi_val;
      age_nxt = hi_age + AGE_ONE;
    end else if (lo_move.up) begin
      val_nxt = lo_val;
      age_nxt = lo_age + AGE_ONE;
    end else if (stay) begin
      val_nxt = val_r;
      age_nxt = age_r + AGE_ONE;
    end else begin
      val_nxt = new_val;
      age_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
      age_r <= AGE_BITS'(INDEX);
    end else if (adv) begin
      val_r <= val_nxt;
      age_r <= age_nxt;
    end
  end

  assign val_o      = val_r;
  assign age_o      = age_r;
  assign old_o      = is_old;
  assign next_old_o = (WINDOW > 1) && (age_r == AGE_BITS'(WINDOW - 2));

endmodule

`default_nettype wire

FILE: rtl/core/sliding_window_median_filter.sv
// The median of a sample is registered and shown on out_ in the cycle after its in_ beat.
// Throughput: one beat per cycle; the sorted cell row inserts one sample and
// evicts the oldest on each accepted beat, and out_median is read straight from the
// middle cell, so the next beat waits only while a result is held stalled.
// Reset (rst_n low, synchronous): every window entry is zero and counts in the
// median until overwritten; no result is pending.
`default_nettype none

module sliding_window_median_filter #(
  parameter int WINDOW      = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed      [SAMPLE_BITS-1:0] out_median
);

  import swmf_pkg::*;

`include "assert_macros.svh"

  localparam int AGE_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int MID      = WINDOW / 2;

  // Row of cells, kept sorted by (value, age): cell 0 holds the smallest.
  logic signed [SAMPLE_BITS-1:0] cell_val [WINDOW];
  logic        [AGE_BITS-1:0]    cell_age [WINDOW];
  swmf_move_t                    cell_move [WINDOW];
  logic        [WINDOW-1:0]      old_vec;
  logic        [WINDOW-1:0]      next_old_vec;

  logic accept;
  logic out_valid_r, out_valid_nxt;
  // Value of the entry to evict on the next beat, prepared one beat ahead.
  logic signed [SAMPLE_BITS-1:0] old_val_r, old_val_nxt, next_old_sel;

  // Hold off new beats only while a finished result is stalled; the middle
  // cell is the output register and must not move under it.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  for (genvar g = 0; g < WINDOW; g++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] lo_val, hi_val;
    logic        [AGE_BITS-1:0]    lo_age, hi_age;
    swmf_move_t                    lo_move, hi_move;

    if (g == 0) begin : g_lo_edge
      assign lo_val  = '0;
      assign lo_age  = '0;
      assign lo_move = '0;
    end else begin : g_lo_link
      assign lo_val  = cell_val[g-1];
      assign lo_age  = cell_age[g-1];
      assign lo_move = cell_move[g-1];
    end

    if (g == WINDOW - 1) begin : g_hi_edge
      assign hi_val  = '0;
      assign hi_age  = '0;
      assign hi_move = '0;
    end else begin : g_hi_link
      assign hi_val  = cell_val[g+1];
      assign hi_age  = cell_age[g+1];
      assign hi_move = cell_move[g+1];
    end

    swmf_cell #(
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS),
      .INDEX       (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .adv        (accept),
      .new_val    (in_sample),
      .old_val    (old_val_r),
      .lo_val     (lo_val),
      .lo_age     (lo_age),
      .lo_move    (lo_move),
      .hi_val     (hi_val),
      .hi_age     (hi_age),
      .hi_move    (hi_move),
      .val_o      (cell_val[g]),
      .age_o      (cell_age[g]),
      .move_o     (cell_move[g]),
      .old_o      (old_vec[g]),
      .next_old_o (next_old_vec[g])
    );
  end

  // Pick the entry that becomes the oldest after this beat. Its value does not
  // change on the beat, so read it from the current cells; with a one-entry
  // window the new sample itself is next out.
  if (WINDOW > 1) begin : g_next_old
    always_comb begin
      next_old_sel = '0;
      for (int i = 0; i < WINDOW; i++) begin
        next_old_sel = next_old_sel | (next_old_vec[i] ? cell_val[i] : '0);
      end
    end
  end else begin : g_next_old_single
    assign next_old_sel = in_sample;
  end

  assign old_val_nxt = accept ? next_old_sel : old_val_r;

  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      old_val_r   <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      old_val_r   <= old_val_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_median = cell_val[MID];

  // Checks: row stays sorted, exactly one oldest entry, the prepared eviction
  // value matches that entry, each accepted beat yields a result, a stalled one holds.
  logic [WINDOW-1:0] order_ok;
  logic [WINDOW-1:0] old_match;

  always_comb begin
    order_ok = '1;
    for (int i = 0; i < WINDOW - 1; i++) begin
      order_ok[i] = (cell_val[i] <= cell_val[i+1]);
    end
  end

  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      old_match[i] = old_vec[i] && (cell_val[i] == old_val_r);
    end
  end

  `SWMF_ASSERT_ALWAYS(a_row_sorted, &order_ok)
  `SWMF_ASSERT_ALWAYS(a_one_oldest, $onehot(old_vec))
  `SWMF_ASSERT_ALWAYS(a_old_val_match, |old_match)
  `SWMF_ASSERT_NEXT(a_result_follows, accept, out_valid)
  `SWMF_ASSERT_IMPL(a_held_result_frozen, $past(out_valid && out_stall) && out_valid,
                    $stable(out_median))

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW      = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int MEDIAN_RANK = WINDOW / 2;  // upper median for an even window
  localparam int IDLE_LIMIT  = 2000;        // cycles with no beat on either side
  localparam int RANDOM_SAMPLES = 900;
  localparam int PRINT_LIMIT = 20;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Shapes of the random sample stream.
  typedef enum int {
    SEG_FULL_RANGE,  // any 16-bit value
    SEG_CLUSTER,     // tight spread around a random center, many ties
    SEG_EXTREMES,    // mostly one rail, now and then the other
    SEG_RAMP,        // steady drift that walks the median along
    SEG_NEAR_ZERO    // -1, 0, +1 against the reset zeros
  } segment_t;

  // Receiver back-pressure patterns.
  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_TOGGLE,
    STALL_HEAVY,
    STALL_LONG
  } stall_mode_t;

  logic    clk       = 1'b0;
  logic    rst_n     = 1'b0;
  logic    in_valid  = 1'b0;
  logic    in_stall;
  sample_t in_sample = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  sample_t out_median;

  // Shadow copy of the filter window and its write pointer.
  sample_t     window_q [WINDOW];
  int unsigned write_idx;
  sample_t     expected_medians [$];

  int error_count   = 0;
  int samples_sent  = 0;
  int samples_taken = 0;
  int medians_out   = 0;
  int window_wraps  = 0;
  int burst_left    = 0;
  int idle_cycles   = 0;
  int stall_cycle   = 0;
  int stall_run     = 0;
  stall_mode_t stall_mode = STALL_NONE;
  sample_t want_median;
  sample_t lowest_median  = SAMPLE_MAX;
  sample_t highest_median = SAMPLE_MIN;

  sliding_window_median_filter #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_median (out_median)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Rank selection over a private copy of the window: insertion-sort it and
  // pick the middle entry. Ties keep their own slots, so no tie rule is needed.
  function automatic sample_t median_of_window();
    sample_t ranked [WINDOW];
    sample_t key;
    int j;
    ranked = window_q;
    for (int i = 1; i < WINDOW; i++) begin
      key = ranked[i];
      j = i - 1;
      while (j >= 0 && ranked[j] > key) begin
        ranked[j+1] = ranked[j];
        j--;
      end
      ranked[j+1] = key;
    end
    return ranked[MEDIAN_RANK];
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= PRINT_LIMIT) begin
      $display("[%0t] MISMATCH: %s", $time, what);
    end
  endtask

  // Sample side: on every accepted beat overwrite the oldest slot, advance the
  // pointer and queue the median the block must answer with.
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (window_q[i]) window_q[i] = '0;
      write_idx = 0;
    end else if (in_valid && !in_stall) begin
      window_q[write_idx] = in_sample;
      write_idx = (write_idx + 1) % WINDOW;
      if (write_idx == 0) begin
        window_wraps++;
      end
      samples_taken++;
      expected_medians.push_back(median_of_window());
    end
  end

  // Median side: compare every accepted beat with the oldest queued median.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      medians_out++;
      if (expected_medians.size() == 0) begin
        report_mismatch($sformatf("median beat %0d with no sample behind it", out_median));
      end else begin
        want_median = expected_medians.pop_front();
        if (out_median !== want_median) begin
          report_mismatch($sformatf("median #%0d: got %0d, want %0d",
                                    medians_out, out_median, want_median));
        end
        if (want_median < lowest_median)  lowest_median  = want_median;
        if (want_median > highest_median) highest_median = want_median;
      end
    end
  end

  // Receiver stall pattern: pick a new random style periodically from stall_cycle so
  // that stalls land on every phase of the sender's bursts, with clean stretches in between.
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1;
    if (stall_cycle % 128 == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 4));
    end
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
      STALL_TOGGLE: out_stall <= ~out_stall;
      STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
      STALL_LONG: begin
        // Hold stall for a run of cycles now and then.
        if (stall_run > 0) begin
          out_stall <= 1'b1;
          stall_run <= stall_run - 1;
        end else begin
          out_stall <= 1'b0;
          if ($urandom_range(0, 15) == 0) stall_run <= $urandom_range(5, 30);
        end
      end
      default:      out_stall <= 1'b0;
    endcase
  end

  // Watchdog: end the run if neither side moves a beat for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[%0t] no beat for %0d cycles", $time, IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Send one sample. The sender runs in bursts; at the end of a burst drop
  // valid for a random gap, then hold the beat until it is taken.
  task automatic send_sample(input sample_t value);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 25) : $urandom_range(0, 4);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 200)
                                                : $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    in_sample <= value;
    do @(posedge clk); while (in_stall);
    samples_sent++;
  endtask

  // Drop valid and hold off until every sent sample has its median back.
  task automatic wait_for_drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (medians_out < samples_sent) @(posedge clk);
  endtask

  // Warm-up with rail values: the reset zeros still outvote them, so the
  // median must stay at zero while the window is mostly unwritten.
  task automatic test_warmup_extremes();
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample('0);
    send_sample(-1);
    send_sample(1);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(sample_t'(16'h5555));
    send_sample(sample_t'(16'hAAAA));
  endtask

  // Repeated values: each copy takes its own rank.
  task automatic test_equal_values();
    repeat (6) send_sample(-7);
    repeat (4) send_sample(7);
  endtask

  // Random stream built from segments of different shapes. Long one-rail
  // segments push more than half the window onto a rail, so the median
  // itself reaches the extremes.
  task automatic test_random_stream(input int total);
    int sent;
    int run;
    sample_t center;
    sample_t rail;
    sample_t step;
    segment_t shape;
    sent = 0;
    while (sent < total) begin
      shape  = segment_t'($urandom_range(0, 4));
      run    = $urandom_range(8, 90);
      center = sample_t'($urandom);
      rail   = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      step   = sample_t'($urandom_range(0, 2047)) - sample_t'(1024);
      for (int k = 0; k < run && sent < total; k++) begin
        case (shape)
          SEG_FULL_RANGE: send_sample(sample_t'($urandom));
          SEG_CLUSTER:    send_sample(center + sample_t'($urandom_range(0, 6)) - sample_t'(3));
          SEG_EXTREMES:   send_sample(($urandom_range(0, 4) == 0) ? ~rail : rail);
          SEG_RAMP:       send_sample(center + sample_t'(k) * step);
          SEG_NEAR_ZERO:  send_sample(sample_t'($urandom_range(0, 2)) - sample_t'(1));
          default:        send_sample(sample_t'($urandom));
        endcase
        sent++;
      end
    end
  endtask

  // Let the pipe run dry mid-stream, then resume with a back-to-back burst.
  task automatic test_drain_then_resume();
    wait_for_drain();
    burst_left = 8;
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample('0);
  endtask

  initial begin
    // Hold reset low from time zero, then release it once.
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_warmup_extremes();
    test_equal_values();
    test_random_stream(RANDOM_SAMPLES / 2);
    test_drain_then_resume();
    test_random_stream(RANDOM_SAMPLES / 2);

    // Wait out the tail, then give any stray beat time to show.
    wait_for_drain();
    repeat (4) @(posedge clk);
    if (expected_medians.size() != 0) begin
      report_mismatch($sformatf("%0d medians never arrived", expected_medians.size()));
    end

    $display("Covered %0d samples and %0d medians; the window wrapped %0d times.",
             samples_taken, medians_out, window_wraps);
    $display("Medians seen ran from %0d to %0d; %0d mismatches.",
             lowest_median, highest_median, error_count);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/swmf_pkg.sv
rtl/core/swmf_cell.sv
rtl/core/sliding_window_median_filter.sv
bench/tb_top.sv
